>>> hdl/tqss_pkg.sv
// Shared types and constants of the two-queue sticky service scheduler.
package tqss_pkg;

    // Field widths of the stream items.
    localparam int FUNC_W     = 2;
    localparam int SVC_W      = 32;
    localparam int ARR_W      = 48;
    localparam int STATUS_W   = 2;
    localparam int CLASS_W    = 2;
    localparam int TIME_OUT_W = 48;
    localparam int CNT_W      = 32;
    localparam int DEPTH_W    = 7;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 280;

    // Item kinds on the input side.
    localparam logic [FUNC_W-1:0] FUNC_ENQ1 = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENQ2 = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDLED    = 2'd3;

    // Class codes.
    localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_1    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_2    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted item
        logic prep;   // queue heads are being read, idle gap is formed
        logic exec;   // apply the item and load the result
    } cmd_t;

endpackage

>>> hdl/tqss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tqss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tqss_ctrl.sv
// Controller state machine: input handshake, sequencing and output valid.
module tqss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output tqss_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   exec_go;

    // The result register may be reloaded once it is empty or being taken.
    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign cmd.load = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.prep = (state_reg == S_READ);
    assign cmd.exec = exec_go;

endmodule

>>> hdl/tqss_dp.sv
// Datapath: class queues, pointers, class choice and saturating accumulators.
module tqss_dp #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tqss_pkg::cmd_t                      cmd,
    input  logic [tqss_pkg::FUNC_W-1:0]         func,
    input  logic [tqss_pkg::SVC_W-1:0]          service_time,
    input  logic [tqss_pkg::ARR_W-1:0]          next_arrival_time,
    output logic [tqss_pkg::STATUS_W-1:0]       status,
    output logic [tqss_pkg::CLASS_W-1:0]        served_class,
    output logic [tqss_pkg::TIME_OUT_W-1:0]     finish_time,
    output logic [tqss_pkg::CNT_W-1:0]          served_count_1,
    output logic [tqss_pkg::CNT_W-1:0]          served_count_2,
    output logic [tqss_pkg::TIME_OUT_W-1:0]     busy_time_1,
    output logic [tqss_pkg::TIME_OUT_W-1:0]     busy_time_2,
    output logic [tqss_pkg::TIME_OUT_W-1:0]     idle_time,
    output logic [tqss_pkg::DEPTH_W-1:0]        queue_depth_1,
    output logic [tqss_pkg::DEPTH_W-1:0]        queue_depth_2,
    output logic [tqss_pkg::CLASS_W-1:0]        last_class
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = TIME_WIDTH;
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [QW-1:0] CNT_FULL = QW'(QUEUE_DEPTH);

    // Captured item.
    logic [tqss_pkg::FUNC_W-1:0] func_reg;
    logic [tqss_pkg::SVC_W-1:0]  svc_reg;
    logic [TW-1:0]               arr_reg;
    logic [63:0]                 arr_wide;

    // Queue control state.
    logic [PW-1:0] rd1_reg, rd1_next, wr1_reg, wr1_next;
    logic [PW-1:0] rd2_reg, rd2_next, wr2_reg, wr2_next;
    logic [QW-1:0] cnt1_reg, cnt1_next, cnt2_reg, cnt2_next;

    // Accumulators.
    logic [TW-1:0]                     finish_reg, finish_next;
    logic [TW-1:0]                     busy1_reg, busy1_next, busy2_reg, busy2_next;
    logic [TW-1:0]                     idle_reg, idle_next;
    logic [tqss_pkg::CNT_W-1:0]        done1_reg, done1_next, done2_reg, done2_next;
    logic [tqss_pkg::CLASS_W-1:0]      last_reg, last_next;

    // Idle gap, formed while the queue heads are read.
    logic          gt_reg;
    logic [TW-1:0] gap_reg;

    // Result payload.
    logic [tqss_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [tqss_pkg::CLASS_W-1:0]  class_reg, class_next;

    // Queue storage.
    logic                        we1, we2;
    logic [tqss_pkg::SVC_W-1:0]  head1, head2;

    // Serve arithmetic.
    logic [tqss_pkg::CLASS_W-1:0] pick;
    logic [tqss_pkg::SVC_W-1:0]   t_sel;
    logic [TW:0]                  fin_sum, busy1_sum, busy2_sum, idle_sum_w;
    logic [TW-1:0]                fin_sat, busy1_sat, busy2_sat, idle_sat;
    logic                         serve_op;

    tqss_ram #(.WIDTH(tqss_pkg::SVC_W), .DEPTH(QUEUE_DEPTH)) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (wr1_reg),
        .wdata (svc_reg),
        .raddr (rd1_reg),
        .rdata (head1)
    );

    tqss_ram #(.WIDTH(tqss_pkg::SVC_W), .DEPTH(QUEUE_DEPTH)) u_ram2 (
        .clk   (clk),
        .we    (we2),
        .waddr (wr2_reg),
        .wdata (svc_reg),
        .raddr (rd2_reg),
        .rdata (head2)
    );

    // Arrival time is kept to the width of the time registers.
    assign arr_wide = 64'(next_arrival_time);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            svc_reg  <= service_time;
            arr_reg  <= arr_wide[TW-1:0];
        end
        if (cmd.prep)
        begin
            gt_reg  <= (arr_reg > finish_reg);
            gap_reg <= arr_reg - finish_reg;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            class_reg  <= class_next;
        end
    end

    assign serve_op = func_reg[1];
    assign we1 = cmd.exec && (func_reg == tqss_pkg::FUNC_ENQ1) && (cnt1_reg != CNT_FULL);
    assign we2 = cmd.exec && (func_reg == tqss_pkg::FUNC_ENQ2) && (cnt2_reg != CNT_FULL);

    // Stay with the last class while it has work; the first choice goes to
    // the shorter head, class 1 on a tie.
    always_comb
    begin
        unique case (last_reg)
            tqss_pkg::CLASS_1:
            begin
                pick = (cnt1_reg != '0) ? tqss_pkg::CLASS_1 : tqss_pkg::CLASS_2;
            end
            tqss_pkg::CLASS_2:
            begin
                pick = (cnt2_reg != '0) ? tqss_pkg::CLASS_2 : tqss_pkg::CLASS_1;
            end
            default:
            begin
                if (cnt1_reg != '0 && cnt2_reg != '0)
                begin
                    pick = (head1 <= head2) ? tqss_pkg::CLASS_1 : tqss_pkg::CLASS_2;
                end
                else
                begin
                    pick = (cnt1_reg != '0) ? tqss_pkg::CLASS_1 : tqss_pkg::CLASS_2;
                end
            end
        endcase
    end

    assign t_sel      = (pick == tqss_pkg::CLASS_1) ? head1 : head2;
    assign fin_sum    = {1'b0, finish_reg} + (TW + 1)'(t_sel);
    assign busy1_sum  = {1'b0, busy1_reg} + (TW + 1)'(t_sel);
    assign busy2_sum  = {1'b0, busy2_reg} + (TW + 1)'(t_sel);
    assign idle_sum_w = {1'b0, idle_reg} + {1'b0, gap_reg};
    assign fin_sat    = fin_sum[TW] ? '1 : fin_sum[TW-1:0];
    assign busy1_sat  = busy1_sum[TW] ? '1 : busy1_sum[TW-1:0];
    assign busy2_sat  = busy2_sum[TW] ? '1 : busy2_sum[TW-1:0];
    assign idle_sat   = idle_sum_w[TW] ? '1 : idle_sum_w[TW-1:0];

    always_comb
    begin
        rd1_next    = rd1_reg;
        wr1_next    = wr1_reg;
        cnt1_next   = cnt1_reg;
        rd2_next    = rd2_reg;
        wr2_next    = wr2_reg;
        cnt2_next   = cnt2_reg;
        finish_next = finish_reg;
        busy1_next  = busy1_reg;
        busy2_next  = busy2_reg;
        idle_next   = idle_reg;
        done1_next  = done1_reg;
        done2_next  = done2_reg;
        last_next   = last_reg;
        status_next = tqss_pkg::ST_ENQUEUED;
        class_next  = tqss_pkg::CLASS_NONE;

        if (!serve_op)
        begin
            if (we1)
            begin
                wr1_next  = (wr1_reg == PTR_LAST) ? '0 : wr1_reg + 1'b1;
                cnt1_next = cnt1_reg + 1'b1;
            end
            else if (we2)
            begin
                wr2_next  = (wr2_reg == PTR_LAST) ? '0 : wr2_reg + 1'b1;
                cnt2_next = cnt2_reg + 1'b1;
            end
            else
            begin
                status_next = tqss_pkg::ST_DROPPED;
            end
        end
        else if (cnt1_reg == '0 && cnt2_reg == '0)
        begin
            status_next = tqss_pkg::ST_IDLED;
            if (gt_reg)
            begin
                idle_next   = idle_sat;
                finish_next = arr_reg;
            end
        end
        else
        begin
            status_next = tqss_pkg::ST_SERVED;
            class_next  = pick;
            last_next   = pick;
            finish_next = fin_sat;
            if (pick == tqss_pkg::CLASS_1)
            begin
                rd1_next   = (rd1_reg == PTR_LAST) ? '0 : rd1_reg + 1'b1;
                cnt1_next  = cnt1_reg - 1'b1;
                busy1_next = busy1_sat;
                if (done1_reg != '1)
                begin
                    done1_next = done1_reg + 1'b1;
                end
            end
            else
            begin
                rd2_next   = (rd2_reg == PTR_LAST) ? '0 : rd2_reg + 1'b1;
                cnt2_next  = cnt2_reg - 1'b1;
                busy2_next = busy2_sat;
                if (done2_reg != '1)
                begin
                    done2_next = done2_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd1_reg    <= '0;
            wr1_reg    <= '0;
            cnt1_reg   <= '0;
            rd2_reg    <= '0;
            wr2_reg    <= '0;
            cnt2_reg   <= '0;
            finish_reg <= '0;
            busy1_reg  <= '0;
            busy2_reg  <= '0;
            idle_reg   <= '0;
            done1_reg  <= '0;
            done2_reg  <= '0;
            last_reg   <= tqss_pkg::CLASS_NONE;
        end
        else if (cmd.exec)
        begin
            rd1_reg    <= rd1_next;
            wr1_reg    <= wr1_next;
            cnt1_reg   <= cnt1_next;
            rd2_reg    <= rd2_next;
            wr2_reg    <= wr2_next;
            cnt2_reg   <= cnt2_next;
            finish_reg <= finish_next;
            busy1_reg  <= busy1_next;
            busy2_reg  <= busy2_next;
            idle_reg   <= idle_next;
            done1_reg  <= done1_next;
            done2_reg  <= done2_next;
            last_reg   <= last_next;
        end
    end

    // Widen to 64 bits first so every time and depth width maps onto the ports.
    logic [63:0] finish_w, busy1_w, busy2_w, idle_w, cnt1_w, cnt2_w;

    assign finish_w = 64'(finish_reg);
    assign busy1_w  = 64'(busy1_reg);
    assign busy2_w  = 64'(busy2_reg);
    assign idle_w   = 64'(idle_reg);
    assign cnt1_w   = 64'(cnt1_reg);
    assign cnt2_w   = 64'(cnt2_reg);

    assign status         = status_reg;
    assign served_class   = class_reg;
    assign finish_time    = finish_w[tqss_pkg::TIME_OUT_W-1:0];
    assign served_count_1 = done1_reg;
    assign served_count_2 = done2_reg;
    assign busy_time_1    = busy1_w[tqss_pkg::TIME_OUT_W-1:0];
    assign busy_time_2    = busy2_w[tqss_pkg::TIME_OUT_W-1:0];
    assign idle_time      = idle_w[tqss_pkg::TIME_OUT_W-1:0];
    assign queue_depth_1  = cnt1_w[tqss_pkg::DEPTH_W-1:0];
    assign queue_depth_2  = cnt2_w[tqss_pkg::DEPTH_W-1:0];
    assign last_class     = last_reg;

endmodule

>>> hdl/two_queue_sticky_service_scheduler.sv
// Top level of the two-queue sticky service scheduler.
//
// The block holds two job queues, one per class, of QUEUE_DEPTH service times each.
// Input items arrive on the s_ channel: s_tuser says what the item does (enqueue to
// class 1, enqueue to class 2, or serve; any code with bit 1 set serves), s_tdata
// carries the service time and the next arrival time. Every input item produces
// exactly one result item on the m_ channel: m_tuser holds the status, m_tdata
// holds the served class and a snapshot of all accumulators and queue depths.
//
// After acceptance an item first passes a read step, which reads both queue heads
// from their RAMs, then an update step, which picks a class and updates the
// saturating accumulators. A new item is taken only once the last one is through;
// s_tready is high only while no item is in work. The result sits in an output
// register, so a new item is accepted while the previous result still waits; the
// update step waits only if that register is still full when the next result is ready.
//
// Reset (rst_n low, asynchronous) empties both queues, clears all accumulators and
// the last-served class, and drops any pending result. Queue RAM contents are not
// cleared; only written entries are ever read. When the receiver holds m_tready low,
// m_tvalid and m_tdata stay put, and input acceptance stops after one more item.
module two_queue_sticky_service_scheduler #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Bits from 0: service_time[31:0], next_arrival_time[79:32].
    input  logic [tqss_pkg::S_TDATA_W-1:0]     s_tdata,
    // Bits from 0: func[1:0].
    input  logic [tqss_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Bits from 0: served_class[1:0], finish_time[49:2], served_count_1[81:50],
    // served_count_2[113:82], busy_time_1[161:114], busy_time_2[209:162],
    // idle_time[257:210], queue_depth_1[264:258], queue_depth_2[271:265],
    // last_class[273:272], zero fill [279:274].
    output logic [tqss_pkg::M_TDATA_W-1:0]     m_tdata,
    // Bits from 0: status[1:0].
    output logic [tqss_pkg::STATUS_W-1:0]      m_tuser
);

    tqss_pkg::cmd_t cmd;

    logic [tqss_pkg::CLASS_W-1:0]    served_class;
    logic [tqss_pkg::TIME_OUT_W-1:0] finish_time;
    logic [tqss_pkg::CNT_W-1:0]      served_count_1;
    logic [tqss_pkg::CNT_W-1:0]      served_count_2;
    logic [tqss_pkg::TIME_OUT_W-1:0] busy_time_1;
    logic [tqss_pkg::TIME_OUT_W-1:0] busy_time_2;
    logic [tqss_pkg::TIME_OUT_W-1:0] idle_time;
    logic [tqss_pkg::DEPTH_W-1:0]    queue_depth_1;
    logic [tqss_pkg::DEPTH_W-1:0]    queue_depth_2;
    logic [tqss_pkg::CLASS_W-1:0]    last_class;

    tqss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tqss_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .func              (s_tuser),
        .service_time      (s_tdata[31:0]),
        .next_arrival_time (s_tdata[79:32]),
        .status            (m_tuser),
        .served_class      (served_class),
        .finish_time       (finish_time),
        .served_count_1    (served_count_1),
        .served_count_2    (served_count_2),
        .busy_time_1       (busy_time_1),
        .busy_time_2       (busy_time_2),
        .idle_time         (idle_time),
        .queue_depth_1     (queue_depth_1),
        .queue_depth_2     (queue_depth_2),
        .last_class        (last_class)
    );

    // The snapshot fields are the state registers themselves; they only change
    // when a new result is loaded, so they hold while the result waits.
    assign m_tdata = {6'b0, last_class, queue_depth_2, queue_depth_1, idle_time,
                      busy_time_2, busy_time_1, served_count_2, served_count_1,
                      finish_time, served_class};

endmodule

>>> hdl/tqss_checker.sv
// Port-level checks of the scheduler, attached to the top level by bind.
module tqss_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [tqss_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic [tqss_pkg::FUNC_W-1:0]        s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tqss_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [tqss_pkg::STATUS_W-1:0]      m_tuser
);

    // An accepted item keeps the input closed while the queue heads are read.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input reopened too early after an accepted item");

    // A stalled result holds its payload.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Only a served result names a class.
    a_class_only_served: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != tqss_pkg::ST_SERVED) |-> (m_tdata[1:0] == tqss_pkg::CLASS_NONE))
        else $error("class reported without a service");

    // A served class becomes the last-served class and is a real class.
    a_last_follows_served: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == tqss_pkg::ST_SERVED) |->
        (m_tdata[273:272] == m_tdata[1:0] &&
         (m_tdata[1:0] == tqss_pkg::CLASS_1 || m_tdata[1:0] == tqss_pkg::CLASS_2)))
        else $error("last class does not match served class");

endmodule

bind two_queue_sticky_service_scheduler tqss_checker u_tqss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
